/* hw/rtl/rts_cts_mac_handshake_top_assert.svh */
// assertion macros used by the handshake mac checker
`ifndef RTS_CTS_MAC_HANDSHAKE_TOP_ASSERT_SVH
`define RTS_CTS_MAC_HANDSHAKE_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define RCMH_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define RCMH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/rcmh_pkg.sv */
// shared types and codes of the rts/cts handshake mac
package rcmh_pkg;

	// depth of the deferred send request queue
	localparam int DEFER_DEPTH_DEF = 4;

	// most results one event can cause
	localparam int RES_MAX = 3;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEXT_HOP = 1'd1;

	// event kinds
	localparam logic [1:0] REQ_SEND = 2'd0;
	localparam logic [1:0] REQ_RECV = 2'd1;
	localparam logic [1:0] REQ_DONE = 2'd2;

	// frame kinds
	localparam logic [1:0] PKT_DATA = 2'd0;
	localparam logic [1:0] PKT_RTS  = 2'd1;
	localparam logic [1:0] PKT_CTS  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_FRAME   = 2'd0;
	localparam logic [1:0] KIND_SENT    = 2'd1;
	localparam logic [1:0] KIND_DELIVER = 2'd2;
	localparam logic [1:0] KIND_DROP    = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] frame_type;
		logic [7:0] frame_src;
		logic [7:0] frame_dst;
		logic [7:0] payload_tag;
	} req_item_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [1:0] out_frame_type;
		logic [7:0] out_src;
		logic [7:0] out_dst;
		logic [7:0] out_tag;
		logic       last;
	} rsp_item_t;

	// defer queue control and status
	typedef struct packed {
		logic push;
		logic pop;
	} dq_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} dq_stat_t;

endpackage

/* hw/rtl/rcmh_defer_fifo.sv */
// queue of send requests deferred while the mac is busy
module rcmh_defer_fifo #(
	parameter int DEPTH = rcmh_pkg::DEFER_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rcmh_pkg::dq_ctl_t ctl,
	input  logic [7:0]        wdata,
	output rcmh_pkg::dq_stat_t stat,
	output logic [7:0]        head_data
);
	import rcmh_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [7:0]    mem [DEPTH];
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [CW-1:0] cnt_q;
	logic [7:0]    head_data_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_q] <= wdata;
		end
	end

	// front entry kept in a register, refilled from the array on pop
	always_ff @(posedge clk) begin
		if (ctl.push && cnt_q == '0) begin
			head_data_q <= wdata;
		end else if (ctl.pop) begin
			head_data_q <= mem[next_ptr(head_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (ctl.push) begin
				tail_q <= next_ptr(tail_q);
				cnt_q  <= cnt_q + 1'b1;
			end else if (ctl.pop) begin
				head_q <= next_ptr(head_q);
				cnt_q  <= cnt_q - 1'b1;
			end
		end
	end

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign head_data  = head_data_q;

endmodule

/* hw/rtl/rts_cts_mac_handshake_top.sv */
// rts/cts/data floor acquisition mac: sender and receiver control
//
// Takes one event per clock on the req channel when req_stall is low (send request
// from above, frame from the radio, radio send done) and answers with zero to three
// result beats on the rsp channel (frames to the radio, send done and delivery
// notices, dropped requests). The event is decoded in the cycle it is accepted; its
// results land in a three-entry result register and leave one beat per cycle while
// rsp_stall is low, the last one flagged by rsp.last. An event that causes one
// result or none flows at one per cycle while rsp_stall is low; one that causes more
// results holds the req channel while the result register drains. A send
// request that arrives while a handshake is in progress waits in a DEFER_DEPTH deep
// queue and is started on the next return to idle; a request that finds the queue
// full comes back as a drop beat carrying its tag. own_address and next_hop_address
// are written through the cfg port and should only change while no event is in
// flight.
module rts_cts_mac_handshake_top #(
	parameter int DEFER_DEPTH = rcmh_pkg::DEFER_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration writes
	input  logic                          cfg_we,
	input  logic [rcmh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	// event channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  rcmh_pkg::req_item_t           req,
	// result channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output rcmh_pkg::rsp_item_t           rsp
);
	import rcmh_pkg::*;

	// handshake modes
	localparam logic [1:0] MODE_IDLE      = 2'd0;
	localparam logic [1:0] MODE_WAIT_RSP  = 2'd1;  // waiting for radio send done
	localparam logic [1:0] MODE_WAIT_CTS  = 2'd2;
	localparam logic [1:0] MODE_WAIT_DATA = 2'd3;

	// configuration registers
	logic [7:0] own_addr_q;
	logic [7:0] next_hop_q;

	// handshake state
	logic [1:0] mode_q, mode_d;
	logic [1:0] pend_q, pend_d;     // kind of frame whose send done is awaited
	logic [7:0] saved_tag_q;
	logic       save_en;
	logic [7:0] save_val;

	// result register
	rsp_item_t  res_q [RES_MAX];
	rsp_item_t  res_d [RES_MAX];
	logic [1:0] cnt_q;              // beats still to deliver
	logic [1:0] rd_q;               // next beat to deliver
	logic [1:0] n_d;

	// defer queue
	dq_ctl_t    dq_ctl;
	dq_stat_t   dq_stat;
	logic [7:0] dq_head;

	logic acc;
	logic out_acc;
	logic idle_ret;
	logic for_me;

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= '0;
			next_hop_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OWN_ADDR: own_addr_q <= cfg_data;
				REG_NEXT_HOP: next_hop_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// an event gets in when the result register is empty or its last beat leaves now
	assign req_stall = (cnt_q > 2'd1) || (cnt_q == 2'd1 && rsp_stall);
	assign acc       = req_valid && !req_stall;
	assign rsp_valid = (cnt_q != 2'd0);
	assign out_acc   = rsp_valid && !rsp_stall;
	assign for_me    = (req.frame_dst == own_addr_q);

	// event decode
	always_comb begin
		mode_d   = mode_q;
		pend_d   = pend_q;
		save_en  = 1'b0;
		save_val = req.payload_tag;
		dq_ctl   = '0;
		idle_ret = 1'b0;
		n_d      = 2'd0;
		for (int i = 0; i < RES_MAX; i++) begin
			res_d[i] = '0;
		end

		if (acc) begin
			case (req.req_type)
				REQ_SEND: begin
					if (mode_q == MODE_IDLE) begin
						// start the handshake with an rts
						res_d[0] = '{out_kind: KIND_FRAME, out_frame_type: PKT_RTS,
							out_src: own_addr_q, out_dst: next_hop_q, out_tag: 8'd0,
							last: 1'b0};
						n_d     = 2'd1;
						save_en = 1'b1;
						pend_d  = PKT_RTS;
						mode_d  = MODE_WAIT_RSP;
					end else if (!dq_stat.full) begin
						dq_ctl.push = 1'b1;
					end else begin
						res_d[0] = '{out_kind: KIND_DROP, out_frame_type: PKT_DATA,
							out_src: 8'd0, out_dst: 8'd0, out_tag: req.payload_tag,
							last: 1'b0};
						n_d = 2'd1;
					end
				end
				REQ_RECV: begin
					if (for_me) begin
						if (mode_q == MODE_IDLE && req.frame_type == {6'd0, PKT_RTS}) begin
							// answer an rts with a cts to its sender
							res_d[0] = '{out_kind: KIND_FRAME, out_frame_type: PKT_CTS,
								out_src: own_addr_q, out_dst: req.frame_src,
								out_tag: 8'd0, last: 1'b0};
							n_d    = 2'd1;
							pend_d = PKT_CTS;
							mode_d = MODE_WAIT_RSP;
						end else if (mode_q == MODE_WAIT_CTS &&
							req.frame_type == {6'd0, PKT_CTS}) begin
							// floor acquired: send the data frame and tell the upper layer
							res_d[0] = '{out_kind: KIND_FRAME, out_frame_type: PKT_DATA,
								out_src: own_addr_q, out_dst: next_hop_q,
								out_tag: saved_tag_q, last: 1'b0};
							res_d[1] = '{out_kind: KIND_SENT, out_frame_type: PKT_DATA,
								out_src: 8'd0, out_dst: 8'd0, out_tag: 8'd0, last: 1'b0};
							n_d    = 2'd2;
							pend_d = PKT_DATA;
							mode_d = MODE_WAIT_RSP;
						end else if (mode_q == MODE_WAIT_DATA &&
							req.frame_type == {6'd0, PKT_DATA}) begin
							// data in: send done notice, then the delivery
							res_d[0] = '{out_kind: KIND_SENT, out_frame_type: PKT_DATA,
								out_src: 8'd0, out_dst: 8'd0, out_tag: 8'd0, last: 1'b0};
							res_d[1] = '{out_kind: KIND_DELIVER, out_frame_type: PKT_DATA,
								out_src: req.frame_src, out_dst: req.frame_dst,
								out_tag: req.payload_tag, last: 1'b0};
							n_d      = 2'd2;
							idle_ret = 1'b1;
						end
					end
				end
				REQ_DONE: begin
					if (mode_q == MODE_WAIT_RSP) begin
						case (pend_q)
							PKT_RTS: mode_d = MODE_WAIT_CTS;
							PKT_CTS: mode_d = MODE_WAIT_DATA;
							default: idle_ret = 1'b1;
						endcase
					end
				end
				default: ;
			endcase
		end

		// back to idle: replay the oldest deferred request at once
		if (idle_ret) begin
			mode_d = MODE_IDLE;
			if (!dq_stat.empty) begin
				dq_ctl.pop = 1'b1;
				res_d[n_d] = '{out_kind: KIND_FRAME, out_frame_type: PKT_RTS,
					out_src: own_addr_q, out_dst: next_hop_q, out_tag: 8'd0, last: 1'b0};
				n_d      = n_d + 2'd1;
				save_en  = 1'b1;
				save_val = dq_head;
				pend_d   = PKT_RTS;
				mode_d   = MODE_WAIT_RSP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pend_q <= PKT_DATA;
		end else begin
			mode_q <= mode_d;
			pend_q <= pend_d;
		end
	end

	// saved tag is always written before a data frame reads it
	always_ff @(posedge clk) begin
		if (save_en) begin
			saved_tag_q <= save_val;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < RES_MAX; i++) begin
				res_q[i] <= res_d[i];
			end
		end
	end

	// result beat count and read position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (acc) begin
			cnt_q <= n_d;
			rd_q  <= '0;
		end else if (out_acc) begin
			cnt_q <= cnt_q - 2'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	// current beat, last flag from the remaining count
	always_comb begin
		rsp      = res_q[rd_q];
		rsp.last = (cnt_q == 2'd1);
	end

	rcmh_defer_fifo #(
		.DEPTH(DEFER_DEPTH)
	) u_defer_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (dq_ctl),
		.wdata    (req.payload_tag),
		.stat     (dq_stat),
		.head_data(dq_head)
	);

endmodule

/* hw/rtl/rcmh_checker.sv */
// port-level checks of the handshake mac, bound to the top level
`include "rts_cts_mac_handshake_top_assert.svh"

module rcmh_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_stall,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input rcmh_pkg::rsp_item_t rsp
);
	import rcmh_pkg::*;

	// a stalled beat stays and holds its payload
	`RCMH_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp beat changed while stalled")

	// a beat without last is followed by another beat of the same event
	`RCMH_ASSERT_NEXT(a_rsp_burst, rsp_valid && !rsp_stall && !rsp.last, rsp_valid, "result burst broken before last")

	// no new event while more than one result beat is pending
	`RCMH_ASSERT_SAME(a_req_block, rsp_valid && !rsp.last, req_stall, "event taken while results pending")

	// only frames to the radio carry a frame kind
	`RCMH_ASSERT_SAME(a_kind_ftype, rsp_valid && rsp.out_kind != KIND_FRAME, rsp.out_frame_type == PKT_DATA, "frame kind on a non-frame beat")

endmodule

bind rts_cts_mac_handshake_top rcmh_checker u_rcmh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);
